@@ hdl/kls_pkg.sv @@
// kls_pkg: shared constants and the sequencer state type for the kth largest selector
// no dependencies
`timescale 1ns / 1ps

package kls_pkg;

	// field and register widths
	localparam int DATA_W    = 32;
	localparam int RANK_W    = 5;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 3;

	// default depth of the value store
	localparam int K_MAX_DEF = 16;

	// register map: bit 2 of paddr selects the register slot
	localparam logic REG_RANK_K = 1'b0;

	// reset value of rank_k
	localparam logic [RANK_W-1:0] RANK_RESET = 5'd4;

	// insertion sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_TAIL_RD,
		S_TAIL_CMP,
		S_STEP,
		S_CMP,
		S_DONE,
		S_KTH
	} kls_state_t;

endpackage

@@ hdl/kls_store.sv @@
// kls_store: value store, one write port and one read port with registered read data
// no dependencies
`timescale 1ns / 1ps

module kls_store #(
	parameter int DEPTH = 16,
	parameter int IW    = 4,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hdl/kls_ctrl.sv @@
// kls_ctrl: insertion sequencer with one shared signed comparator and the result register
// depends on kls_pkg and kls_store
`timescale 1ns / 1ps

module kls_ctrl #(
	parameter int K_MAX = kls_pkg::K_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [kls_pkg::RANK_W-1:0]        rank_k,
	input  logic signed [kls_pkg::DATA_W-1:0] sample,
	input  logic                              end_of_stream,
	input  logic                              in_valid,
	output logic                              in_ready,
	output logic signed [kls_pkg::DATA_W-1:0] kth_value,
	output logic                              result_valid,
	output logic                              out_valid,
	input  logic                              out_ready
);

	localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
	localparam int CW = $clog2(K_MAX + 1);
	localparam int KW = (CW > kls_pkg::RANK_W) ? CW : kls_pkg::RANK_W;
	localparam int DW = kls_pkg::DATA_W;

	kls_pkg::kls_state_t state_q, state_d;

	logic signed [DW-1:0] sample_q;
	logic                 last_q;
	logic [IW-1:0]        pos_q;
	logic [CW-1:0]        count_q;

	logic signed [DW-1:0] kth_value_q;
	logic                 result_valid_q;
	logic                 out_valid_q;

	logic          wr_en, rd_en;
	logic [IW-1:0] wr_addr, rd_addr;
	logic [DW-1:0] wr_data, rd_data;

	logic          full;
	logic          rd_lt;
	logic          slot_free;
	logic [KW-1:0] rank_ext, k_eff, k_m1;
	logic          enough;

	kls_store #(
		.DEPTH (K_MAX),
		.IW    (IW),
		.DW    (DW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// shared comparator: stored value below the incoming sample
	assign rd_lt = $signed(rd_data) < sample_q;

	assign full      = count_q == CW'(K_MAX);
	assign slot_free = !out_valid_q || out_ready;

	// clamp rank to 1..K_MAX
	always_comb begin
		rank_ext = KW'(rank_k);
		if (rank_ext == '0) begin
			k_eff = KW'(1);
		end else if (rank_ext > KW'(K_MAX)) begin
			k_eff = KW'(K_MAX);
		end else begin
			k_eff = rank_ext;
		end
		k_m1   = k_eff - KW'(1);
		enough = KW'(count_q) >= k_eff;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kls_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = full ? kls_pkg::S_TAIL_RD : kls_pkg::S_STEP;
				end
			end
			kls_pkg::S_TAIL_RD:  state_d = kls_pkg::S_TAIL_CMP;
			kls_pkg::S_TAIL_CMP: state_d = rd_lt ? kls_pkg::S_STEP : kls_pkg::S_DONE;
			kls_pkg::S_STEP:     state_d = (pos_q == '0) ? kls_pkg::S_DONE : kls_pkg::S_CMP;
			kls_pkg::S_CMP:      state_d = rd_lt ? kls_pkg::S_STEP : kls_pkg::S_DONE;
			kls_pkg::S_DONE:     state_d = last_q ? kls_pkg::S_KTH : kls_pkg::S_IDLE;
			kls_pkg::S_KTH: begin
				if (slot_free) begin
					state_d = kls_pkg::S_IDLE;
				end
			end
			default: state_d = kls_pkg::S_IDLE;
		endcase
	end

	// store access and handshake outputs per state
	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = pos_q;
		wr_data  = sample_q;
		unique case (state_q)
			kls_pkg::S_IDLE: in_ready = 1'b1;
			kls_pkg::S_TAIL_RD: begin
				rd_en   = 1'b1;
				rd_addr = IW'(K_MAX - 1);
			end
			kls_pkg::S_TAIL_CMP: begin
			end
			kls_pkg::S_STEP: begin
				if (pos_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = pos_q - IW'(1);
				end
			end
			kls_pkg::S_CMP: begin
				wr_en   = 1'b1;
				wr_data = rd_lt ? rd_data : sample_q;
			end
			kls_pkg::S_DONE: begin
				rd_en   = last_q;
				rd_addr = k_m1[IW-1:0];
			end
			kls_pkg::S_KTH: begin
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kls_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == kls_pkg::S_IDLE && in_valid && !full) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == kls_pkg::S_KTH && slot_free) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
			end
		end
	end

	// item and position registers
	always_ff @(posedge clk) begin
		if (state_q == kls_pkg::S_IDLE && in_valid) begin
			sample_q <= sample;
			last_q   <= end_of_stream;
			pos_q    <= full ? IW'(K_MAX - 1) : count_q[IW-1:0];
		end
		if (state_q == kls_pkg::S_CMP && rd_lt) begin
			pos_q <= pos_q - IW'(1);
		end
		if (state_q == kls_pkg::S_KTH && slot_free) begin
			kth_value_q    <= enough ? $signed(rd_data) : '0;
			result_valid_q <= enough;
		end
	end

	assign kth_value    = kth_value_q;
	assign result_valid = result_valid_q;
	assign out_valid    = out_valid_q;

	// held count never passes the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(K_MAX))
		else $error("held count beyond store depth");

	// an accepted item keeps the sequencer busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after an accepted item");

	// a shift step never reads below entry zero
	a_step_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kls_pkg::S_STEP && rd_en |-> pos_q != '0)
		else $error("shift read at position zero");

	// a result appears only from the kth fetch state, which clears the count
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == kls_pkg::S_KTH) && count_q == '0)
		else $error("result without kth fetch");

endmodule

@@ hdl/stream_kth_largest_select_top.sv @@
// stream_kth_largest_select_top: APB rank register and the insertion sequencer
// depends on kls_pkg and kls_ctrl
`timescale 1ns / 1ps

// Keeps the K_MAX largest samples of a stream in a store sorted from largest to smallest
// and, on the item marked end_of_stream, gives the kth largest value (rank_k, clamped to
// 1..K_MAX) with result_valid low and a zero value when fewer than k samples arrived; the
// stream state then clears for the next stream. Each item is placed by insertion through
// the store's single read port and one signed comparator: a step reads the entry above
// the sample's place and moves it down while it is smaller than the sample; a full store
// first compares the sample with its last entry and drops it unless it is larger, and an
// item marked last then fetches the kth entry; in_ready is high only between items.
// A finished result sits in an output register, so the next item can be taken while
// it waits.

module stream_kth_largest_select_top #(
	parameter int K_MAX = kls_pkg::K_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [kls_pkg::APB_AW-1:0]        paddr,
	input  logic [kls_pkg::APB_DW-1:0]        pwdata,
	output logic [kls_pkg::APB_DW-1:0]        prdata,
	output logic                              pready,
	input  logic signed [kls_pkg::DATA_W-1:0] sample,
	input  logic                              end_of_stream,
	input  logic                              in_valid,
	output logic                              in_ready,
	output logic signed [kls_pkg::DATA_W-1:0] kth_value,
	output logic                              result_valid,
	output logic                              out_valid,
	input  logic                              out_ready
);

	logic [kls_pkg::RANK_W-1:0] rank_k_q;
	logic                       reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2] == kls_pkg::REG_RANK_K;

	// rank register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_k_q <= kls_pkg::RANK_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			rank_k_q <= pwdata[kls_pkg::RANK_W-1:0];
		end
	end

	// register read back
	assign prdata = reg_sel ? kls_pkg::APB_DW'(rank_k_q) : '0;

	kls_ctrl #(
		.K_MAX (K_MAX)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.rank_k        (rank_k_q),
		.sample        (sample),
		.end_of_stream (end_of_stream),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kth_value     (kth_value),
		.result_valid  (result_valid),
		.out_valid     (out_valid),
		.out_ready     (out_ready)
	);

endmodule

@@ verif/stream_kth_largest_select_top_test.sv @@
// stream_kth_largest_select_top_test: directed and random streams, rank_k settings and back-pressure
// depends on kls_pkg and stream_kth_largest_select_top
`timescale 1ns / 1ps

module stream_kth_largest_select_top_test;
	import kls_pkg::*;

	localparam int DEPTH        = K_MAX_DEF;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int RANDOM_ITEMS = 1860;
	localparam int HOLD_CYCLES  = 400;

	// byte address of rank_k: bit 2 of paddr picks the register
	localparam logic [APB_AW-1:0] RANK_K_ADDR = {REG_RANK_K, 2'b00};

	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

	typedef enum int {MIX_FULL, MIX_NARROW, MIX_EXTREME, MIX_RISING, MIX_FALLING} value_mix_t;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     valid;
	} kth_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_AW-1:0]        paddr;
	logic [APB_DW-1:0]        pwdata;
	logic [APB_DW-1:0]        prdata;
	logic                     pready;
	logic signed [DATA_W-1:0] sample;
	logic                     end_of_stream;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [DATA_W-1:0] kth_value;
	logic                     result_valid;
	logic                     out_valid;
	logic                     out_ready;

	// predictor state: the largest values seen, sorted from largest down
	logic signed [DATA_W-1:0] top_list [DEPTH];
	int unsigned              held_n = 0;
	logic [RANK_W-1:0]        rank_reg = RANK_RESET;
	kth_result_t              kth_expect_q [$];

	int  cycle_count    = 0;
	int  mismatch_count = 0;
	int  items_sent     = 0;
	int  hold_off_req   = 0;
	bit  no_gaps        = 1'b0;

	stream_kth_largest_select_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.sample        (sample),
		.end_of_stream (end_of_stream),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kth_value     (kth_value),
		.result_valid  (result_valid),
		.out_valid     (out_valid),
		.out_ready     (out_ready)
	);

	// clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// run limit
	initial begin
		while (cycle_count < LIMIT_CYCLES) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	function automatic void flag_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endfunction

	// insert one sample into the sorted list, dropping it when the list is full and it is too small
	function automatic void insert_sample(logic signed [DATA_W-1:0] v);
		int unsigned n;
		int unsigned pos;
		n = held_n;
		if (n == DEPTH) begin
			if (v <= top_list[DEPTH-1])
				return;
			pos = DEPTH - 1;
		end else begin
			pos = n;
			n++;
		end
		while (pos > 0 && top_list[pos-1] < v) begin
			top_list[pos] = top_list[pos-1];
			pos--;
		end
		top_list[pos] = v;
		held_n = n;
	endfunction

	// update the predictor with one accepted item; a last item queues the kth largest value
	function automatic void absorb_item(logic signed [DATA_W-1:0] v, logic last);
		int unsigned k;
		kth_result_t res;
		insert_sample(v);
		if (last) begin
			k = rank_reg;
			if (k < 1)
				k = 1;
			if (k > DEPTH)
				k = DEPTH;
			if (held_n >= k) begin
				res.value = top_list[k-1];
				res.valid = 1'b1;
			end else begin
				res.value = '0;
				res.valid = 1'b0;
			end
			kth_expect_q.push_back(res);
			held_n = 0;
		end
	endfunction

	// result receiver: random stalls, or a long hold-off when one is requested
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_req != 0) begin
				stall = hold_off_req;
				hold_off_req = 0;
			end else begin
				stall = no_gaps ? 0 : $urandom_range(0, 11);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// compare each accepted result with the oldest expected one
	always @(posedge clk) begin
		kth_result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (kth_expect_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected result kth_value %0d result_valid %b",
					kth_value, result_valid));
			end else begin
				want = kth_expect_q.pop_front();
				if (kth_value !== want.value)
					flag_mismatch($sformatf("kth_value expected %0d got %0d",
						want.value, kth_value));
				if (result_valid !== want.valid)
					flag_mismatch($sformatf("result_valid expected %b got %b",
						want.valid, result_valid));
			end
		end
	end

	// send one item; starts and ends at a falling edge
	task automatic send_item(input logic signed [DATA_W-1:0] v, input logic last);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		sample        <= v;
		end_of_stream <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		absorb_item(v, last);
		items_sent++;
		@(negedge clk);
	endtask

	// stop sending, wait for every expected result, then let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (kth_expect_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// apb write of rank_k, sometimes with junk in the unused upper bits
	task automatic write_rank(input logic [RANK_W-1:0] v);
		logic [APB_DW-RANK_W-1:0] upper;
		upper = ($urandom_range(0, 3) == 0) ? (APB_DW-RANK_W)'($urandom) : '0;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= RANK_K_ADDR;
		pwdata  <= {upper, v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rank_reg = v;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// one stream of random content; may change rank_k halfway while the stream is open
	task automatic send_stream(input int len, input value_mix_t mix, input bit mid_change);
		logic signed [DATA_W-1:0] run_base;
		logic signed [DATA_W-1:0] v;
		run_base = $urandom;
		for (int i = 0; i < len; i++) begin
			if (mid_change && len > 1 && i == len / 2 && $urandom_range(0, 11) == 0) begin
				wait_idle();
				write_rank(RANK_W'($urandom_range(0, 31)));
			end
			case (mix)
				MIX_FULL: v = $urandom;
				MIX_NARROW: v = int'($urandom_range(0, 15)) - 8;
				MIX_EXTREME: begin
					case ($urandom_range(0, 3))
						0: v = S32_MAX;
						1: v = S32_MIN;
						2: v = S32_MAX - 1;
						default: v = S32_MIN + 1;
					endcase
				end
				MIX_RISING: v = run_base + i;
				default: v = run_base - i;
			endcase
			send_item(v, i == len - 1);
		end
	endtask

	// reset rank of 4, extreme samples, and a stream that is too short
	task automatic test_default_rank();
		send_item(S32_MAX, 1'b0);
		send_item(S32_MIN, 1'b0);
		send_item(32'sd0, 1'b0);
		send_item(-32'sd1, 1'b0);
		send_item(32'sd1, 1'b1);
		send_item(32'sd5, 1'b0);
		send_item(32'sd5, 1'b0);
		send_item(32'sd5, 1'b1);
	endtask

	// rank of one, rank of zero read as one, rank above the depth saturated
	task automatic test_rank_limits();
		wait_idle();
		write_rank(5'd1);
		send_item(S32_MIN, 1'b1);
		wait_idle();
		write_rank(5'd0);
		send_item(32'sd7, 1'b0);
		send_item(32'sd7, 1'b1);
		wait_idle();
		write_rank(5'd17);
		send_item(S32_MAX, 1'b0);
		send_item(S32_MAX, 1'b1);
	endtask

	// rank changed while a stream is open
	task automatic test_rank_change_mid_stream();
		wait_idle();
		write_rank(5'd2);
		send_item(32'sd10, 1'b0);
		send_item(32'sd30, 1'b0);
		send_item(32'sd20, 1'b0);
		wait_idle();
		write_rank(5'd3);
		send_item(32'sd40, 1'b1);
	endtask

	// long receiver hold-off while items keep coming, then a full pause of the sender
	task automatic test_backpressure();
		wait_idle();
		write_rank(5'd3);
		no_gaps = 1'b1;
		hold_off_req = HOLD_CYCLES;
		repeat (4) send_stream(6, MIX_FULL, 1'b0);
		wait_idle();
		send_stream(5, MIX_NARROW, 1'b0);
		no_gaps = 1'b0;
	endtask

	// phases of random streams, each under its own rank setting
	task automatic test_random_streams(input int item_goal);
		int phase;
		int first;
		int len;
		logic [RANK_W-1:0] rank;
		phase = 0;
		first = items_sent;
		while (items_sent - first < item_goal) begin
			wait_idle();
			case (phase)
				0: rank = 5'd1;
				1: rank = 5'd16;
				2: rank = 5'd0;
				3: rank = 5'd31;
				4: rank = 5'd17;
				default: rank = RANK_W'($urandom_range(0, 31));
			endcase
			write_rank(rank);
			no_gaps = (phase % 4 == 3);
			repeat (12) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 20);
				send_stream(len, value_mix_t'($urandom_range(0, 4)), 1'b1);
			end
			phase++;
		end
		no_gaps = 1'b0;
	endtask

	// main sequence
	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		sample        = '0;
		end_of_stream = 1'b0;
		in_valid      = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_default_rank();
		test_rank_limits();
		test_rank_change_mid_stream();
		test_backpressure();
		test_random_streams(RANDOM_ITEMS);
		wait_idle();

		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/kls_pkg.sv
hdl/kls_store.sv
hdl/kls_ctrl.sv
hdl/stream_kth_largest_select_top.sv
verif/stream_kth_largest_select_top_test.sv
